// File: design/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared definitions of the multichannel sensor debouncer
// Field widths, register map, request codes and the lane control struct.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Payload field widths.
    localparam int SENSOR_W   = 24;
    localparam int CODE_W     = 24;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    // Request kinds carried in s_tuser.
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration port.
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_INDEX_W = 2;
    localparam int CFG_COUNT_W = 16;

    localparam logic [REG_INDEX_W-1:0] REG_RELOAD = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_STABLE = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_ACTIVE = 2'd2;

    localparam logic [CFG_COUNT_W-1:0] RELOAD_RESET = 16'd20;
    localparam logic [CFG_COUNT_W-1:0] STABLE_RESET = 16'd1;
    localparam logic                   ACTIVE_RESET = 1'b0;

    // Per-transfer control broadcast to every lane.
    typedef struct packed {
        logic tick;
        logic scan;
        logic active_level;
    } lane_ctrl_t;

endpackage

// File: design/msd_lane.sv
// ----------------------------------------------------------------------------
// msd_lane: one debounce channel
// Holds the channel's countdown counter and its stable flag; a tick can age
// the counter, and a scan can update both.
// ----------------------------------------------------------------------------
module msd_lane #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  msd_pkg::lane_ctrl_t      ctrl,
    input  logic                     level,
    input  logic [COUNTER_WIDTH-1:0] load_val,
    input  logic [COUNTER_WIDTH-1:0] floor_val,
    output logic                     stable_next
);
    import msd_pkg::*;

    logic [COUNTER_WIDTH-1:0] counter_reg;
    logic [COUNTER_WIDTH-1:0] counter_next;
    logic                     stable_reg;

    always_comb begin
        counter_next = counter_reg;
        stable_next  = stable_reg;
        if (ctrl.tick) begin
            if (counter_reg > floor_val) begin
                counter_next = counter_reg - COUNTER_WIDTH'(1);
            end
        end else if (ctrl.scan) begin
            if (level == ctrl.active_level) begin
                // A counter at zero is always reloaded, even when the floor is zero.
                if (counter_reg == '0) begin
                    counter_next = load_val;
                end else if (counter_reg == floor_val) begin
                    stable_next = 1'b1;
                end
            end else begin
                counter_next = '0;
                stable_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            stable_reg  <= 1'b0;
        end else begin
            counter_reg <= counter_next;
            stable_reg  <= stable_next;
        end
    end

endmodule

// File: design/msd_merge.sv
// ----------------------------------------------------------------------------
// msd_merge: result merging and output buffering
// Gathers the lane flags into the debounced code, compares the flags with the
// last reported flags, and holds results in an output register plus a skid entry.
// ----------------------------------------------------------------------------
module msd_merge #(
    parameter int CHANNELS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           scan_accept,
    input  logic [CHANNELS-1:0]            stable_next,
    output logic                           in_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser
);
    import msd_pkg::*;

    logic [CHANNELS-1:0] reported_reg;
    logic                changed;
    logic [CODE_W-1:0]   code;

    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic                out_changed_reg;
    logic                skid_valid_reg;
    logic [CODE_W-1:0]   skid_code_reg;
    logic                skid_changed_reg;
    logic                out_pop;

    // Channels above the code width still count toward the change flag.
    assign changed  = (stable_next != reported_reg);
    assign code     = CODE_W'(stable_next);
    assign out_pop  = out_valid_reg && m_tready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reported_reg <= '0;
        end else if (scan_accept) begin
            reported_reg <= stable_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (scan_accept) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_pop) begin
                out_code_reg    <= skid_code_reg;
                out_changed_reg <= skid_changed_reg;
            end
        end else if (scan_accept) begin
            if (out_valid_reg && !m_tready) begin
                skid_code_reg    <= code;
                skid_changed_reg <= changed;
            end else begin
                out_code_reg    <= code;
                out_changed_reg <= changed;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = M_TDATA_W'(out_code_reg);
    assign m_tuser[0] = out_changed_reg;

endmodule

// File: design/multichannel_sensor_debouncer_core.sv
// ----------------------------------------------------------------------------
// multichannel_sensor_debouncer_core: per-channel countdown debouncer
// Debounces CHANNELS sensor inputs; ticks age the counters, scans update
// them and return the debounced code with a change flag.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle, tick or scan, while s_tready
// is high; a scan's result is registered in the output register, or in the
// skid entry while the output is held. Every channel has its own lane with a
// counter, updated by compares and a load, clear or decrement. Results wait
// in the output register and one skid entry; s_tready falls only while both
// are full. Ticks produce no result transfer. Configuration is written at
// APB byte addresses 0 (reload count), 4 (stable count) and 8 (active level).
module multichannel_sensor_debouncer_core #(
    parameter int CHANNELS      = 24,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream. s_tdata: sensor_levels[23:0]. s_tuser: req_type[0].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                      s_tuser,
    // Result stream. m_tdata: debounced_code[23:0]. m_tuser: changed[0].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [0:0]                      m_tuser,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [msd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [msd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import msd_pkg::*;

    logic [CFG_COUNT_W-1:0]   reload_count_reg;
    logic [CFG_COUNT_W-1:0]   stable_count_reg;
    logic                     active_level_reg;
    logic                     cfg_write;
    logic [REG_INDEX_W-1:0]   reg_index;

    logic                     in_accept;
    lane_ctrl_t               lane_ctrl;
    logic [COUNTER_WIDTH-1:0] load_val;
    logic [COUNTER_WIDTH-1:0] floor_val;
    logic [CHANNELS-1:0]      stable_next;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_count_reg <= RELOAD_RESET;
            stable_count_reg <= STABLE_RESET;
            active_level_reg <= ACTIVE_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                REG_RELOAD: reload_count_reg <= pwdata[CFG_COUNT_W-1:0];
                REG_STABLE: stable_count_reg <= pwdata[CFG_COUNT_W-1:0];
                REG_ACTIVE: active_level_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_RELOAD: prdata = APB_DATA_W'(reload_count_reg);
            REG_STABLE: prdata = APB_DATA_W'(stable_count_reg);
            REG_ACTIVE: prdata = APB_DATA_W'(active_level_reg);
            default:    prdata = '0;
        endcase
    end

    // Counts are cut or widened to the counter width where they are used.
    assign load_val  = COUNTER_WIDTH'(reload_count_reg);
    assign floor_val = COUNTER_WIDTH'(stable_count_reg);

    assign in_accept              = s_tvalid && s_tready;
    assign lane_ctrl.tick         = in_accept && (s_tuser[0] == REQ_TICK);
    assign lane_ctrl.scan         = in_accept && (s_tuser[0] == REQ_SCAN);
    assign lane_ctrl.active_level = active_level_reg;

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        logic level;
        if (ch < SENSOR_W) begin : g_sensed
            assign level = s_tdata[ch];
        end else begin : g_unsensed
            // Channels beyond the sensor field always read low.
            assign level = 1'b0;
        end

        msd_lane #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (lane_ctrl),
            .level       (level),
            .load_val    (load_val),
            .floor_val   (floor_val),
            .stable_next (stable_next[ch])
        );
    end

    msd_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .scan_accept (lane_ctrl.scan),
        .stable_next (stable_next),
        .in_ready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // A stalled input means the skid entry is full, so the output must be too.
    a_stall_needs_full_output: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid
    ) else $error("input stalled while no result is pending");

    // A tick never creates a result transfer.
    a_tick_no_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (lane_ctrl.tick && !m_tvalid) |=> !m_tvalid
    ) else $error("result appeared after a tick");

    // A scan into an empty output shows its result on the next cycle.
    a_scan_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (lane_ctrl.scan && !m_tvalid) |=> m_tvalid
    ) else $error("scan result missing");

endmodule

// File: tb/tb_multichannel_sensor_debouncer_core.sv
// ----------------------------------------------------------------------------
// tb_multichannel_sensor_debouncer_core: self-checking bench of the debouncer
// Drives scan and tick transfers with random gaps, models every channel
// counter in the bench, and compares each result transfer with its prediction.
// ----------------------------------------------------------------------------
module tb_multichannel_sensor_debouncer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import msd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 180;
    localparam int CH_IDX_W       = $clog2(SENSOR_W);
    localparam logic [REG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic              changed;
        logic [CODE_W-1:0] code;
    } scan_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = REQ_SCAN;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Bench copy of the configuration and of the per-channel state.
    logic [CFG_COUNT_W-1:0] reload_cfg = RELOAD_RESET;
    logic [CFG_COUNT_W-1:0] stable_cfg = STABLE_RESET;
    logic                   active_cfg = ACTIVE_RESET;
    logic [CFG_COUNT_W-1:0] lane_count [SENSOR_W];
    logic [CODE_W-1:0]      stable_flags = '0;
    logic [CODE_W-1:0]      last_reported = '0;

    scan_result_t expected_scans [$];

    int  error_count = 0;
    int  idle_cycles = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  stall_left = 0;
    bit  burst_mode = 1'b0;
    bit  quiet_mode = 1'b0;

    multichannel_sensor_debouncer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    initial begin
        foreach (lane_count[ch]) lane_count[ch] = '0;
    end

    // Applies one accepted transfer to the bench state of all channels.
    function automatic void debounce_update(input logic req,
                                            input logic [SENSOR_W-1:0] levels);
        scan_result_t res;
        if (req == REQ_TICK) begin
            for (int ch = 0; ch < SENSOR_W; ch++) begin
                if (lane_count[ch] > stable_cfg)
                    lane_count[ch] = lane_count[ch] - CFG_COUNT_W'(1);
            end
        end else begin
            for (int ch = 0; ch < SENSOR_W; ch++) begin
                if (levels[ch] == active_cfg) begin
                    if (lane_count[ch] == '0) begin
                        lane_count[ch] = reload_cfg;
                    end else if (lane_count[ch] == stable_cfg) begin
                        stable_flags[ch] = 1'b1;
                    end
                end else begin
                    lane_count[ch]   = '0;
                    stable_flags[ch] = 1'b0;
                end
            end
            res.changed   = (stable_flags != last_reported);
            res.code      = stable_flags;
            last_reported = stable_flags;
            expected_scans.push_back(res);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic req, input logic [SENSOR_W-1:0] levels);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = levels;
        do @(posedge aclk); while (!s_tready);
        debounce_update(req, levels);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [REG_INDEX_W-1:0] index,
                             input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_RELOAD: reload_cfg = data[CFG_COUNT_W-1:0];
            REG_STABLE: stable_cfg = data[CFG_COUNT_W-1:0];
            REG_ACTIVE: active_cfg = data[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Ticks leave no result behind, so the task waits on past the drained queue to cover the last one.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (expected_scans.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Upper data bits are random so that the register truncation is exercised.
    task automatic set_config(input logic [CFG_COUNT_W-1:0] reload,
                              input logic [CFG_COUNT_W-1:0] stable,
                              input logic active);
        wait_idle();
        apb_write(REG_RELOAD, {16'($urandom_range(0, 16'hFFFF)), reload});
        apb_write(REG_STABLE, {16'($urandom_range(0, 16'hFFFF)), stable});
        apb_write(REG_ACTIVE, {31'($urandom_range(0, 31'h7FFF_FFFF)), active});
    endtask

    task automatic test_reset_values();
        send_item(REQ_SCAN, 24'h000000);
        send_item(REQ_TICK, 24'hFFFFFF);
        send_item(REQ_SCAN, 24'hFFFFFF);
    endtask

    task automatic test_stable_detect();
        set_config(16'd2, 16'd1, 1'b1);
        send_item(REQ_SCAN, 24'hFFFFFF);
        send_item(REQ_TICK, 24'h000000);
        send_item(REQ_SCAN, 24'hFFFFFF);
        send_item(REQ_SCAN, 24'hFFFFFF);
        send_item(REQ_SCAN, 24'h555555);
        send_item(REQ_SCAN, 24'h000000);
    endtask

    // With a zero stable count a counter at zero is reloaded and never stable.
    task automatic test_zero_stable();
        set_config(16'd0, 16'd0, 1'b0);
        send_item(REQ_SCAN, 24'h000000);
        send_item(REQ_SCAN, 24'h000000);
        set_config(16'd3, 16'd0, 1'b0);
        send_item(REQ_SCAN, 24'h0F0F0F);
        repeat (3) send_item(REQ_TICK, SENSOR_W'($urandom_range(0, 24'hFFFFFF)));
        send_item(REQ_SCAN, 24'h0F0F0F);
    endtask

    // A stable count above the reload count keeps the counter from aging.
    task automatic test_max_counts();
        set_config(16'hFFFF, 16'hFFFF, 1'b0);
        send_item(REQ_SCAN, 24'h000000);
        send_item(REQ_TICK, 24'h000000);
        send_item(REQ_SCAN, 24'h000000);
        set_config(16'd2, 16'd5, 1'b1);
        send_item(REQ_SCAN, 24'hFFFFFF);
        send_item(REQ_TICK, 24'hFFFFFF);
        send_item(REQ_SCAN, 24'hFFFFFF);
    endtask

    // A write past the register map must leave the configuration alone.
    task automatic test_unmapped_write();
        wait_idle();
        apb_write(REG_UNMAPPED, $urandom());
        send_item(REQ_SCAN, 24'hFFFFFF);
        send_item(REQ_SCAN, 24'h000000);
    endtask

    // The receiver holds off while scans keep coming, so the input stalls.
    task automatic test_backpressure();
        set_config(16'd1, 16'd1, 1'b1);
        burst_mode = 1'b1;
        hold_requests++;
        repeat (40) send_item(REQ_SCAN, SENSOR_W'($urandom_range(0, 24'hFFFFFF)));
        burst_mode = 1'b0;
    endtask

    task automatic test_random_phases();
        logic [SENSOR_W-1:0] held_levels;
        logic [SENSOR_W-1:0] levels;
        logic [CFG_COUNT_W-1:0] reload;
        logic [CH_IDX_W-1:0] flip_ch;
        for (int phase = 0; phase < 6; phase++) begin
            reload = CFG_COUNT_W'($urandom_range(1, 6));
            case (phase)
                1: set_config(16'hFFFF, 16'hFFFE, 1'($urandom_range(0, 1)));
                3: set_config(16'd1, 16'd0, 1'($urandom_range(0, 1)));
                4: set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)));
                default: set_config(reload, 16'($urandom_range(0, reload)),
                                    1'($urandom_range(0, 1)));
            endcase
            quiet_mode  = (phase == 2);
            burst_mode  = (phase == 2);
            held_levels = SENSOR_W'($urandom_range(0, 24'hFFFFFF));
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 45) begin
                    send_item(REQ_TICK, SENSOR_W'($urandom_range(0, 24'hFFFFFF)));
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        flip_ch = CH_IDX_W'($urandom_range(0, SENSOR_W-1));
                        held_levels[flip_ch] ^= 1'b1;
                    end
                    if ($urandom_range(0, 49) == 0)
                        held_levels = SENSOR_W'($urandom_range(0, 24'hFFFFFF));
                    levels = held_levels;
                    // A single-scan glitch on one channel models contact bounce.
                    if ($urandom_range(0, 99) < 15) begin
                        flip_ch = CH_IDX_W'($urandom_range(0, SENSOR_W-1));
                        levels[flip_ch] ^= 1'b1;
                    end
                    send_item(REQ_SCAN, levels);
                end
            end
            quiet_mode = 1'b0;
            burst_mode = 1'b0;
        end
    endtask

    always @(negedge aclk) begin
        int r;
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left  = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (quiet_mode) begin
            m_tready = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready = 1'b1;
            end else begin
                m_tready   = 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
        end
    end

    always @(posedge aclk) begin
        scan_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_scans.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR: result transfer with nothing expected: changed=%0d code=%06h",
                             m_tuser[0], m_tdata);
            end else begin
                exp_res = expected_scans.pop_front();
                if (m_tuser[0] !== exp_res.changed || m_tdata !== exp_res.code) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: expected changed=%0d code=%06h, got changed=%0d code=%06h",
                                 exp_res.changed, exp_res.code, m_tuser[0], m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("multichannel_sensor_debouncer_core test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_values();
        test_stable_detect();
        test_zero_stable();
        test_max_counts();
        test_unmapped_write();
        test_backpressure();
        test_random_phases();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && expected_scans.size() == 0) begin
            $display("multichannel_sensor_debouncer_core test passed");
        end else begin
            $display("multichannel_sensor_debouncer_core test failed");
        end
        $finish;
    end

endmodule
